// ===== design/h264fu_pkg.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter package
// Shared types and constants for the front classifier, command queue and
// beat expander.
// ---------------------------------------------------------------------------
package h264fu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 24;
    localparam int unsigned FMAX_W = 12;

    localparam logic [FMAX_W-1:0] FMAX_FLOOR = 12'd16;
    localparam logic [FMAX_W-1:0] FMAX_RESET = 12'd1400;

    localparam logic [4:0] FU_A_TYPE = 5'd28;
    localparam logic [7:0] FU_S_BIT  = 8'h80;
    localparam logic [7:0] FU_E_BIT  = 8'h40;

    // One queued command: either a single byte, or an FU indicator,
    // FU header and data byte triple.
    typedef struct packed {
        logic              fu;
        logic              beg;
        logic              pend;
        logic              nend;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] ind;
        logic [BYTE_W-1:0] hdr;
    } fu_cmd_t;

endpackage

// ===== design/h264fu_front.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter front end
// Accepts NAL bytes, tracks unit and fragment state, and turns each byte
// into a command for the queue (or nothing).
// ---------------------------------------------------------------------------
module h264fu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [h264fu_pkg::FMAX_W-1:0] fmax_cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [h264fu_pkg::BYTE_W-1:0] data_byte,
    input  logic                          first_of_nal,
    input  logic [h264fu_pkg::SIZE_W-1:0] nal_size,
    input  logic                          q_full,
    output logic                          push,
    output h264fu_pkg::fu_cmd_t           cmd
);
    import h264fu_pkg::*;

    logic [BYTE_W-1:0] held_reg,  held_next;
    logic [SIZE_W-1:0] rem_reg,   rem_next;
    logic [FMAX_W-1:0] fill_reg,  fill_next;
    logic              frag_reg,  frag_next;
    logic              ffrag_reg, ffrag_next;

    logic              accept;
    logic              emit;
    logic [FMAX_W-1:0] fmax;
    logic [SIZE_W-1:0] fmax_ext;
    logic [SIZE_W-1:0] rem_dec;
    logic [FMAX_W-1:0] fill_inc;
    logic              frag_end;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign fmax     = (fmax_cfg < FMAX_FLOOR) ? FMAX_FLOOR : fmax_cfg;
    assign fmax_ext = {{(SIZE_W-FMAX_W){1'b0}}, fmax};
    assign rem_dec  = rem_reg - 1'b1;
    assign fill_inc = fill_reg + 1'b1;
    assign frag_end = (fill_inc >= fmax) || (rem_dec == '0)
                      || (ffrag_reg && (rem_dec == {{(SIZE_W-1){1'b0}}, 1'b1}));

    always_comb
    begin
        held_next  = held_reg;
        rem_next   = rem_reg;
        fill_next  = fill_reg;
        frag_next  = frag_reg;
        ffrag_next = ffrag_reg;
        emit       = 1'b0;
        cmd        = '0;
        cmd.data   = data_byte;
        cmd.ind    = {held_reg[7:5], FU_A_TYPE};
        cmd.hdr    = {3'b000, held_reg[4:0]};
        if (first_of_nal)
        begin
            held_next  = data_byte;
            fill_next  = '0;
            ffrag_next = 1'b1;
            rem_next   = (nal_size == '0) ? '0 : nal_size - 1'b1;
            if (nal_size <= fmax_ext)
            begin
                frag_next = 1'b0;
                emit      = 1'b1;
                cmd.beg   = 1'b1;
                cmd.pend  = (nal_size <= {{(SIZE_W-1){1'b0}}, 1'b1});
                cmd.nend  = cmd.pend;
            end
            else
            begin
                frag_next = 1'b1;
            end
        end
        else if (rem_reg == '0)
        begin
            emit = 1'b0;
        end
        else if (!frag_reg)
        begin
            rem_next = rem_dec;
            emit     = 1'b1;
            cmd.pend = (rem_dec == '0);
            cmd.nend = (rem_dec == '0);
        end
        else
        begin
            emit     = 1'b1;
            rem_next = rem_dec;
            cmd.fu   = (fill_reg == '0);
            cmd.beg  = cmd.fu;
            if (ffrag_reg)
                cmd.hdr = cmd.hdr | FU_S_BIT;
            else if (rem_reg <= fmax_ext)
                cmd.hdr = cmd.hdr | FU_E_BIT;
            cmd.pend = frag_end;
            cmd.nend = (rem_dec == '0);
            if (frag_end)
            begin
                fill_next  = '0;
                ffrag_next = 1'b0;
            end
            else
            begin
                fill_next = fill_inc;
            end
            if (rem_dec == '0)
                frag_next = 1'b0;
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            rem_reg   <= '0;
            fill_reg  <= '0;
            frag_reg  <= 1'b0;
            ffrag_reg <= 1'b1;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            rem_reg   <= rem_next;
            fill_reg  <= fill_next;
            frag_reg  <= frag_next;
            ffrag_reg <= ffrag_next;
        end
    end

endmodule

// ===== design/h264fu_queue.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter command queue
// Small register FIFO that decouples the front end from the beat expander.
// ---------------------------------------------------------------------------
module h264fu_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  h264fu_pkg::fu_cmd_t push_cmd,
    input  logic                pop,
    output h264fu_pkg::fu_cmd_t head_cmd,
    output logic                full,
    output logic                empty
);
    import h264fu_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fu_cmd_t         mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/h264fu_back.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter beat expander
// Expands queued commands into one or three output beats through a
// registered output stage.
// ---------------------------------------------------------------------------
module h264fu_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  h264fu_pkg::fu_cmd_t           head_cmd,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [h264fu_pkg::BYTE_W-1:0] out_byte,
    output logic                          packet_begin,
    output logic                          packet_end,
    output logic                          nal_end,
    output logic                          run_last
);
    import h264fu_pkg::*;

    typedef enum logic [1:0] {
        PH_IND,
        PH_HDR,
        PH_DATA
    } phase_t;

    phase_t            phase_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              beg_reg;
    logic              pend_reg;
    logic              nend_reg;
    logic              last_reg;
    logic              advance;
    logic              load;

    assign advance = !valid_reg || !out_stall;
    assign load    = advance && !empty;
    assign pop     = load && (!head_cmd.fu || (phase_reg == PH_DATA));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IND;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            beg_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            nend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= !empty;
            if (!empty)
            begin
                if (!head_cmd.fu)
                begin
                    byte_reg  <= head_cmd.data;
                    beg_reg   <= head_cmd.beg;
                    pend_reg  <= head_cmd.pend;
                    nend_reg  <= head_cmd.nend;
                    last_reg  <= 1'b1;
                    phase_reg <= PH_IND;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_IND:
                        begin
                            byte_reg  <= head_cmd.ind;
                            beg_reg   <= 1'b1;
                            pend_reg  <= 1'b0;
                            nend_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            phase_reg <= PH_HDR;
                        end
                        PH_HDR:
                        begin
                            byte_reg  <= head_cmd.hdr;
                            beg_reg   <= 1'b0;
                            pend_reg  <= 1'b0;
                            nend_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            phase_reg <= PH_DATA;
                        end
                        default:
                        begin
                            byte_reg  <= head_cmd.data;
                            beg_reg   <= 1'b0;
                            pend_reg  <= head_cmd.pend;
                            nend_reg  <= head_cmd.nend;
                            last_reg  <= 1'b1;
                            phase_reg <= PH_IND;
                        end
                    endcase
                end
            end
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign packet_begin = beg_reg;
    assign packet_end   = pend_reg;
    assign nal_end      = nend_reg;
    assign run_last     = last_reg;

endmodule

// ===== design/h264_fu_a_fragmenter_core.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter core
// Turns NAL unit bytes into RTP payload bytes, splitting large units into
// FU-A fragments with FU indicator and FU header bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one NAL byte per beat, header byte
//   first with first_of_nal set and nal_size valid on that beat.
//   Output channel (out_valid / out_stall): one RTP payload byte per beat,
//   with packet_begin / packet_end framing, nal_end on the unit's last byte
//   and run_last on the last beat caused by an input byte.
//   Config: cfg_we writes cfg_wdata into fragment_payload_max (values below
//   16 act as 16). Write only while the block is idle.
// Path: an accepted input byte is written into the command queue and then
//   loaded into the output register; a fragment start leaves as FU
//   indicator, FU header and data byte, in that order.
// Throughput: one output beat per cycle while out_stall is low. Input bytes
//   go through at one per cycle while the queue has room, except that the
//   first byte of each fragment expands into three beats; the command queue
//   (QUEUE_DEPTH entries) absorbs that; in_stall rises only while it is full.
// Reset: fragment_payload_max returns to 1400, the queue empties and no
//   unit is open. A stalled receiver holds the output register; the queue
//   then fills and stalls the input side.
// ---------------------------------------------------------------------------
module h264_fu_a_fragmenter_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [h264fu_pkg::FMAX_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [h264fu_pkg::BYTE_W-1:0] data_byte,
    input  logic                          first_of_nal,
    input  logic [h264fu_pkg::SIZE_W-1:0] nal_size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [h264fu_pkg::BYTE_W-1:0] out_byte,
    output logic                          packet_begin,
    output logic                          packet_end,
    output logic                          nal_end,
    output logic                          run_last
);
    import h264fu_pkg::*;

    logic [FMAX_W-1:0] fmax_reg;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    fu_cmd_t           push_cmd;
    fu_cmd_t           head_cmd;

    // Fragment size register; hold between writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmax_reg <= FMAX_RESET;
        else if (cfg_we)
            fmax_reg <= cfg_wdata;
    end

    // Classify each byte and track unit / fragment state.
    h264fu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .fmax_cfg     (fmax_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first_of_nal (first_of_nal),
        .nal_size     (nal_size),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    // Decouple the two sides so each can stall on its own.
    h264fu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Expand commands into output beats.
    h264fu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .packet_begin (packet_begin),
        .packet_end   (packet_end),
        .nal_end      (nal_end),
        .run_last     (run_last)
    );

    // The last byte of a unit always closes its packet.
    a_nal_end_closes_packet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && nal_end) |-> packet_end
    ) else $error("nal_end without packet_end");

    // A packet start that is not the run's last beat is an FU indicator.
    a_fu_indicator_type: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && packet_begin && !run_last) |-> (out_byte[4:0] == FU_A_TYPE)
    ) else $error("FU indicator has wrong type");

    // An accepted FU indicator is followed at once by its FU header.
    a_fu_header_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && packet_begin && !run_last)
            |=> (out_valid && !packet_begin && !run_last)
    ) else $error("FU header did not follow indicator");

endmodule

// ===== test/tb_h264_fu_a_fragmenter_core.sv =====
// ---------------------------------------------------------------------------
// H.264 FU-A fragmenter core testbench
// Feeds NAL unit bytes through the valid/stall input channel and predicts
// every RTP payload beat: single-packet units, FU indicator and FU header
// insertion, S/E bits and unit truncation. Output beats are compared field
// by field against the predicted stream under several fragment limits and
// idle/stall mixes.
// ---------------------------------------------------------------------------
module tb_h264_fu_a_fragmenter_core;

    import h264fu_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 8;    // covers the two-stage pipeline

    typedef struct packed {
        logic [BYTE_W-1:0] octet;
        logic              first;
        logic [SIZE_W-1:0] size;
    } nal_byte_t;

    typedef struct packed {
        logic [BYTE_W-1:0] octet;
        logic              pbeg;
        logic              pend;
        logic              nend;
        logic              last;
    } rtp_beat_t;

    // -----------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [FMAX_W-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              first_of_nal = 1'b0;
    logic [SIZE_W-1:0] nal_size = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              packet_begin;
    logic              packet_end;
    logic              nal_end;
    logic              run_last;

    h264_fu_a_fragmenter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first_of_nal (first_of_nal),
        .nal_size     (nal_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .packet_begin (packet_begin),
        .packet_end   (packet_end),
        .nal_end      (nal_end),
        .run_last     (run_last)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Testbench state
    // -----------------------------------------------------------------------
    nal_byte_t nal_pending[$];     // bytes waiting to be driven
    nal_byte_t next_byte;
    rtp_beat_t rtp_expected[$];    // predicted payload beats, oldest first
    rtp_beat_t step_beats[$];      // beats caused by the byte being predicted
    rtp_beat_t got_beat;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int gen_left = 0;              // body bytes still owed to the open unit

    // Fragmenter state as the predictor sees it
    logic [FMAX_W-1:0] frag_max_cfg = FMAX_RESET;
    logic [BYTE_W-1:0] held_hdr = '0;
    logic [SIZE_W-1:0] nal_left = '0;
    logic [FMAX_W-1:0] frag_fill = '0;
    logic              in_frag = 1'b0;
    logic              on_first_frag = 1'b1;

    int phase_cfg[6]  = '{16, 20, 0, 4095, 5, 33};
    int phase_mode[6] = '{0, 1, 2, 3, 0, 3};
    int phase_len[6]  = '{40, 35, 30, 30, 30, 25};

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    function automatic void stage_beat(input logic [BYTE_W-1:0] octet, input logic pbeg,
                                       input logic pend, input logic nend);
        rtp_beat_t bt;
        bt.octet = octet;
        bt.pbeg  = pbeg;
        bt.pend  = pend;
        bt.nend  = nend;
        bt.last  = 1'b0;
        step_beats.push_back(bt);
    endfunction

    // Advance the fragmenter state by one accepted byte and queue its beats.
    function automatic void predict_fu_beats(input logic [BYTE_W-1:0] octet,
                                             input logic first,
                                             input logic [SIZE_W-1:0] size);
        logic [FMAX_W-1:0] lim;
        logic [BYTE_W-1:0] fu_hdr;
        logic              close;
        lim = (frag_max_cfg < FMAX_FLOOR) ? FMAX_FLOOR : frag_max_cfg;
        step_beats.delete();
        if (first)
        begin
            // New unit: drop whatever was open before it
            held_hdr = octet;
            frag_fill = '0;
            on_first_frag = 1'b1;
            if (size <= lim)
            begin
                in_frag = 1'b0;
                nal_left = (size == 0) ? '0 : size - 1'b1;
                stage_beat(octet, 1'b1, nal_left == 0, nal_left == 0);
            end
            else
            begin
                // Hold the header back; it only feeds the FU bytes
                in_frag = 1'b1;
                nal_left = size - 1'b1;
            end
        end
        else if (nal_left == 0)
        begin
            // No unit open: drop the byte
        end
        else if (!in_frag)
        begin
            nal_left = nal_left - 1'b1;
            stage_beat(octet, 1'b0, nal_left == 0, nal_left == 0);
        end
        else
        begin
            if (frag_fill == 0)
            begin
                stage_beat({held_hdr[7:5], FU_A_TYPE}, 1'b1, 1'b0, 1'b0);
                fu_hdr = {3'b000, held_hdr[4:0]};
                if (on_first_frag)
                    fu_hdr = fu_hdr | FU_S_BIT;
                else if (nal_left <= lim)
                    fu_hdr = fu_hdr | FU_E_BIT;
                stage_beat(fu_hdr, 1'b0, 1'b0, 1'b0);
            end
            nal_left = nal_left - 1'b1;
            frag_fill = frag_fill + 1'b1;
            // Cut the first fragment one byte short on an exact fit so that
            // no FU header carries both S and E
            close = (frag_fill >= lim) || (nal_left == 0) ||
                    (on_first_frag && nal_left == 1);
            stage_beat(octet, 1'b0, close, nal_left == 0);
            if (close)
            begin
                frag_fill = '0;
                on_first_frag = 1'b0;
            end
            if (nal_left == 0)
                in_frag = 1'b0;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[k])
            rtp_expected.push_back(step_beats[k]);
    endfunction

    // -----------------------------------------------------------------------
    // Driver: present queued bytes, hold a stalled beat, idle at random
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_fu_beats(data_byte, first_of_nal, nal_size);
            // Advance only when the current beat moved or none was offered
            if (!in_valid || !in_stall)
            begin
                if (nal_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = nal_pending.pop_front();
                    in_valid     <= 1'b1;
                    data_byte    <= next_byte.octet;
                    first_of_nal <= next_byte.first;
                    nal_size     <= next_byte.size;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: compare each output beat against the oldest prediction
    // -----------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (rtp_expected.size() == 0)
                begin
                    $error("out_byte: expected no beat, got %0h", out_byte);
                    mismatch_count++;
                end
                else
                begin
                    got_beat = rtp_expected.pop_front();
                    check_field("out_byte", got_beat.octet, out_byte);
                    check_field("packet_begin", got_beat.pbeg, packet_begin);
                    check_field("packet_end", got_beat.pend, packet_end);
                    check_field("nal_end", got_beat.nend, nal_end);
                    check_field("run_last", got_beat.last, run_last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic queue_nal_byte(input logic [BYTE_W-1:0] octet, input logic first,
                                  input logic [SIZE_W-1:0] size);
        nal_byte_t nb;
        nb.octet = octet;
        nb.first = first;
        nb.size  = size;
        nal_pending.push_back(nb);
    endtask

    // Hold until every queued byte went in and every predicted beat came
    // out, then let the pipeline settle so held headers are absorbed too.
    task automatic wait_block_idle();
        do
            @(posedge clk);
        while (nal_pending.size() != 0 || in_valid || rtp_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frag_max(input logic [FMAX_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        frag_max_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed units with random content; a few broken ones, stray
    // bytes and headers announcing huge units that are cut off early.
    // A unit left open at the end carries over into the next phase.
    task automatic queue_random_units(input int budget, input logic [FMAX_W-1:0] cfg_val);
        int count;
        int r;
        int lim;
        logic [SIZE_W-1:0] sz;
        count = 0;
        lim = (cfg_val < FMAX_FLOOR) ? FMAX_FLOOR : cfg_val;
        while (count < budget)
        begin
            r = $urandom_range(99);
            if (gen_left > 0 && r >= 1)
            begin
                queue_nal_byte(8'($urandom_range(255)), 1'b0, 24'($urandom));
                gen_left--;
                count++;
            end
            else if (gen_left == 0 && r < 6)
            begin
                // Stray byte: ignored unless a cut-off unit is still open
                queue_nal_byte(8'($urandom_range(255)), 1'b0, 24'($urandom));
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 5)
                begin
                    sz = '0;
                    gen_left = 0;
                end
                else if (r < 15 && lim <= 64)
                begin
                    sz = SIZE_W'(lim + 1);  // payload fills exactly one fragment
                    gen_left = lim;
                end
                else if (r < 22 && lim <= 64)
                begin
                    sz = SIZE_W'(lim);      // largest single packet
                    gen_left = lim - 1;
                end
                else if (r < 30)
                begin
                    sz = 24'($urandom_range(24'hFFFFFF, 24'h001000));
                    gen_left = $urandom_range(48, 2);
                end
                else
                begin
                    sz = 24'($urandom_range(56, 1));
                    gen_left = sz - 1;
                end
                queue_nal_byte(8'($urandom_range(255)), 1'b1, sz);
                count++;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int i;
        int p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit: one-byte unit, zero size,
        // stray byte with no unit open, two-byte unit
        queue_nal_byte(8'h00, 1'b1, 24'd1);
        queue_nal_byte(8'hFF, 1'b1, 24'd0);
        queue_nal_byte(8'hA5, 1'b0, 24'hFFFFFF);
        queue_nal_byte(8'h65, 1'b1, 24'd2);
        queue_nal_byte(8'hFF, 1'b0, 24'd0);
        wait_block_idle();

        // Register below the floor acts as 16; a payload of exactly 16 bytes
        // must split so the first fragment is one byte short
        write_frag_max(12'd0);
        queue_nal_byte(8'hE5, 1'b1, 24'd17);
        for (i = 0; i < 16; i++)
            queue_nal_byte(8'(8'h10 + i * 15), 1'b0, 24'd0);
        // Open a huge unit and leave it mid-fragment
        queue_nal_byte(8'h41, 1'b1, 24'hFFFFFF);
        queue_nal_byte(8'h12, 1'b0, 24'd0);
        wait_block_idle();

        // Change the limit while that unit is still open, then drop it
        // with a new header before it completes
        write_frag_max(12'd4095);
        queue_nal_byte(8'h34, 1'b0, 24'd0);
        queue_nal_byte(8'h09, 1'b1, 24'd1);
        wait_block_idle();

        // Random phases, each under its own limit and idle/stall mix
        for (p = 0; p < 6; p++)
        begin
            case (phase_mode[p])
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                3:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_frag_max(FMAX_W'(phase_cfg[p]));
            queue_random_units(phase_len[p], FMAX_W'(phase_cfg[p]));
            wait_block_idle();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
